// File: src/dvft_pkg.sv
package dvft_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountOutW  = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } item_t;

  typedef enum logic {
    ST_ABSORB,
    ST_EMIT
  } back_state_e;

endpackage

// File: src/dvft_front.sv
module dvft_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [dvft_pkg::ValueW-1:0] sample_value_i,
  input  logic                              end_of_run_i,
  output logic                              busy_o,
  output dvft_pkg::item_t                   item_o,
  output logic                              item_valid_o,
  input  logic                              pop_i
);
  import dvft_pkg::*;

  item_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   fill_q, fill_d;
  logic             push;
  logic             pop;

  assign busy_o       = (fill_q == (QPtrW+1)'(QueueDepth));
  assign item_valid_o = (fill_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = start_i & ~busy_o;
  assign pop          = pop_i & item_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{value: sample_value_i, last: end_of_run_i};
    end
  end

endmodule

// File: src/dvft_table.sv
module dvft_table #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_WIDTH   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dvft_pkg::item_t                       item_i,
  input  logic                                  item_valid_i,
  output logic                                  pop_o,
  output logic                                  result_valid_o,
  output logic signed [dvft_pkg::ValueW-1:0]    entry_value_o,
  output logic        [dvft_pkg::CountOutW-1:0] entry_count_o,
  output logic                                  table_overflowed_o,
  output logic                                  final_entry_o
);
  import dvft_pkg::*;

  localparam int unsigned UsedW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ExtW  = (COUNT_WIDTH > CountOutW) ? COUNT_WIDTH : CountOutW;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [ValueW-1:0]      val_q [TABLE_ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] append_at;

  back_state_e      state_q, state_d;
  logic [UsedW-1:0] used_q, used_d;
  logic             ovf_q, ovf_d;
  logic             hit;
  logic             full;
  logic             do_absorb;
  logic             do_emit;

  logic              result_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic [ExtW-1:0]   out_count_q;
  logic              out_ovf_q;
  logic              out_final_q;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cmp
    assign match[k]     = (UsedW'(k) < used_q) && (val_q[k] == item_i.value);
    assign append_at[k] = (UsedW'(k) == used_q);
  end

  assign hit  = |match;
  assign full = (used_q == UsedW'(TABLE_ENTRIES));

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    ovf_d     = ovf_q;
    pop_o     = 1'b0;
    do_absorb = 1'b0;
    do_emit   = 1'b0;
    unique case (state_q)
      ST_ABSORB: begin
        pop_o = item_valid_i;
        if (item_valid_i) begin
          do_absorb = 1'b1;
          if (!hit && full) begin
            ovf_d = 1'b1;
          end else if (!hit) begin
            used_d = used_q + 1'b1;
          end
          if (item_i.last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        do_emit = 1'b1;
        used_d  = used_q - 1'b1;
        if (used_q == UsedW'(1)) begin
          ovf_d   = 1'b0;
          state_d = ST_ABSORB;
        end
      end
      default: begin
        state_d = ST_ABSORB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_ABSORB;
      used_q         <= '0;
      ovf_q          <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      used_q         <= used_d;
      ovf_q          <= ovf_d;
      result_valid_q <= do_emit;
    end
  end

  // Emission reads entry zero and shifts the whole table down by one entry.
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (do_emit) begin
        if (k + 1 < TABLE_ENTRIES) begin
          val_q[k] <= val_q[(k + 1) % TABLE_ENTRIES];
          cnt_q[k] <= cnt_q[(k + 1) % TABLE_ENTRIES];
        end
      end else if (do_absorb) begin
        if (match[k]) begin
          if (cnt_q[k] != CountMax) begin
            cnt_q[k] <= cnt_q[k] + 1'b1;
          end
        end else if (!hit && append_at[k]) begin
          val_q[k] <= item_i.value;
          cnt_q[k] <= COUNT_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      out_value_q <= val_q[0];
      out_count_q <= ExtW'(cnt_q[0]);
      out_ovf_q   <= ovf_q;
      out_final_q <= (used_q == UsedW'(1));
    end
  end

  assign result_valid_o     = result_valid_q;
  assign entry_value_o      = out_value_q;
  assign entry_count_o      = out_count_q[CountOutW-1:0];
  assign table_overflowed_o = out_ovf_q;
  assign final_entry_o      = out_final_q;

endmodule

// File: src/distinct_value_frequency_table.sv
// Accepts one item per cycle while the four-entry input queue has room; an accepted item
// updates the table at the next clock edge when no earlier item is queued ahead of it and
// the table is not emitting. An item marked end of run is followed by one result per used
// table entry, one per cycle, registered on the ports once that item is absorbed. The queue
// is not drained meanwhile, so busy can stay high while results are emitted. Results are
// strobed by result_valid_o and cannot be stalled; reset empties the queue and the table.
module distinct_value_frequency_table #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_WIDTH   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [dvft_pkg::ValueW-1:0]    sample_value_i,
  input  logic                                  end_of_run_i,
  output logic                                  result_valid_o,
  output logic signed [dvft_pkg::ValueW-1:0]    entry_value_o,
  output logic        [dvft_pkg::CountOutW-1:0] entry_count_o,
  output logic                                  table_overflowed_o,
  output logic                                  final_entry_o
);
  import dvft_pkg::*;

  item_t queue_item;
  logic  queue_valid;
  logic  queue_pop;

  dvft_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sample_value_i (sample_value_i),
    .end_of_run_i   (end_of_run_i),
    .busy_o         (busy),
    .item_o         (queue_item),
    .item_valid_o   (queue_valid),
    .pop_i          (queue_pop)
  );

  dvft_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_table (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_i             (queue_item),
    .item_valid_i       (queue_valid),
    .pop_o              (queue_pop),
    .result_valid_o     (result_valid_o),
    .entry_value_o      (entry_value_o),
    .entry_count_o      (entry_count_o),
    .table_overflowed_o (table_overflowed_o),
    .final_entry_o      (final_entry_o)
  );

endmodule

// File: tb/distinct_value_frequency_table_tb.sv
module distinct_value_frequency_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dvft_pkg::*;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned TotalItems   = 280;

  typedef struct {
    logic signed [ValueW-1:0]    value;
    logic        [CountOutW-1:0] count;
    logic                        overflowed;
    logic                        final_mark;
  } hist_entry_t;

  typedef struct {
    logic signed [ValueW-1:0]    value;
    int                          step;
    int                          reps;
    bit                          last;
    bit                          typed;
    logic        [CountOutW-1:0] count;
    bit                          overflowed;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic signed [ValueW-1:0]    sample_value_i;
  logic                        end_of_run_i;
  logic                        result_valid_o;
  logic signed [ValueW-1:0]    entry_value_o;
  logic        [CountOutW-1:0] entry_count_o;
  logic                        table_overflowed_o;
  logic                        final_entry_o;

  logic signed [ValueW-1:0]    hist_values [TableEntries];
  logic        [CountOutW-1:0] hist_counts [TableEntries];
  int unsigned                 hist_used;
  bit                          hist_overflow;
  hist_entry_t                 pending_entries[$];

  bit                          typed_row;
  logic        [CountOutW-1:0] typed_count;
  bit                          typed_overflow;
  bit                          burst;
  int unsigned                 error_count;
  int unsigned                 idle_cycles;
  int unsigned                 items_sent;

  distinct_value_frequency_table dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .sample_value_i    (sample_value_i),
    .end_of_run_i      (end_of_run_i),
    .result_valid_o    (result_valid_o),
    .entry_value_o     (entry_value_o),
    .entry_count_o     (entry_count_o),
    .table_overflowed_o(table_overflowed_o),
    .final_entry_o     (final_entry_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 40) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic void absorb_sample(input logic signed [ValueW-1:0] v, input logic last);
    bit          hit;
    hist_entry_t e;
    hit = 1'b0;
    for (int unsigned k = 0; k < hist_used && !hit; k++) begin
      if (hist_values[k] == v) begin
        if (hist_counts[k] != '1) begin
          hist_counts[k]++;
        end
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (hist_used < TableEntries) begin
        hist_values[hist_used] = v;
        hist_counts[hist_used] = 1;
        hist_used++;
      end else begin
        hist_overflow = 1'b1;
      end
    end
    if (last) begin
      if (typed_row) begin
        e.value      = v;
        e.count      = typed_count;
        e.overflowed = typed_overflow;
        e.final_mark = 1'b1;
        pending_entries.push_back(e);
      end else begin
        for (int unsigned k = 0; k < hist_used; k++) begin
          e.value      = hist_values[k];
          e.count      = hist_counts[k];
          e.overflowed = hist_overflow;
          e.final_mark = (k + 1 == hist_used);
          pending_entries.push_back(e);
        end
      end
      hist_used     = 0;
      hist_overflow = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    hist_entry_t e;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_entries.size() == 0) begin
          report_mismatch("unexpected result value", entry_value_o, '0);
        end else begin
          e = pending_entries.pop_front();
          check_field("entry_value", entry_value_o, e.value);
          check_field("entry_count", 32'(entry_count_o), 32'(e.count));
          check_field("table_overflowed", 32'(table_overflowed_o), 32'(e.overflowed));
          check_field("final_entry", 32'(final_entry_o), 32'(e.final_mark));
        end
      end
      if (start && !busy) begin
        absorb_sample(sample_value_i, end_of_run_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic signed [ValueW-1:0] v, input logic last,
                           input bit typed, input logic [CountOutW-1:0] cnt,
                           input bit ovf);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_value_i = v;
    end_of_run_i   = last;
    typed_row      = typed;
    typed_count    = cnt;
    typed_overflow = ovf;
    start          = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic wait_for_drain();
    start = 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_run(ref logic signed [ValueW-1:0] vals[$]);
    burst = ($urandom_range(0, 3) == 0);
    foreach (vals[i]) begin
      send_item(vals[i], i == vals.size() - 1, 1'b0, '0, 1'b0);
    end
  endtask

  initial begin
    stim_row_t                stim_rows[$];
    logic signed [ValueW-1:0] run_vals[$];
    logic signed [ValueW-1:0] pool[$];
    logic signed [ValueW-1:0] extremes[$];
    int unsigned              kind;
    int unsigned              len;
    int unsigned              runs;

    rst_ni         = 1'b0;
    start          = 1'b0;
    sample_value_i = '0;
    end_of_run_i   = 1'b0;
    typed_row      = 1'b0;
    typed_count    = '0;
    typed_overflow = 1'b0;
    burst          = 1'b0;
    error_count    = 0;
    idle_cycles    = 0;
    items_sent     = 0;
    hist_used      = 0;
    hist_overflow  = 1'b0;
    extremes       = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1};

    stim_rows.push_back('{32'sh8000_0000, 0, 1, 1'b1, 1'b1, 16'd1, 1'b0});
    stim_rows.push_back('{32'sh7FFF_FFFF, 0, 1, 1'b1, 1'b1, 16'd1, 1'b0});
    stim_rows.push_back('{32'sh0, 0, 1, 1'b1, 1'b1, 16'd1, 1'b0});
    stim_rows.push_back('{-32'sd1, 0, 1, 1'b1, 1'b1, 16'd1, 1'b0});
    stim_rows.push_back('{32'sd5, 0, 4, 1'b1, 1'b1, 16'd4, 1'b0});
    stim_rows.push_back('{32'sd1, 0, 1, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{32'sd2, 0, 1, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{32'sd1, 0, 1, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{32'sh8000_0000, 0, 1, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{32'sh7FFF_FFFF, 0, 1, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{-32'sd1, 0, 1, 1'b1, 1'b0, 16'd0, 1'b0});
    // The table fills, repeats still count, and new values are dropped.
    stim_rows.push_back('{32'sd100, 1, 64, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{32'sd100, 1, 3, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{-32'sd5, 0, 2, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{32'sd100, 1, 1, 1'b1, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{32'sd200, 1, 64, 1'b1, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{32'sd300, 1, 64, 1'b0, 1'b0, 16'd0, 1'b0});
    stim_rows.push_back('{-32'sd300, 0, 1, 1'b1, 1'b0, 16'd0, 1'b0});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      burst = (stim_rows[i].reps > 100) || ($urandom_range(0, 3) == 0);
      for (int r = 0; r < stim_rows[i].reps; r++) begin
        send_item(stim_rows[i].value + 32'(stim_rows[i].step * r),
                  stim_rows[i].last && (r == stim_rows[i].reps - 1),
                  stim_rows[i].typed, stim_rows[i].count, stim_rows[i].overflowed);
      end
    end
    wait_for_drain();

    runs = 0;
    while (items_sent < TotalItems) begin
      run_vals.delete();
      pool.delete();
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            pool.push_back(extremes[$urandom_range(0, extremes.size() - 1)]);
          end else begin
            pool.push_back($urandom);
          end
        end
        len = $urandom_range(1, 12);
        repeat (len) run_vals.push_back(pool[$urandom_range(0, pool.size() - 1)]);
      end else if (kind < 75) begin
        len = $urandom_range(1, 20);
        repeat (len) run_vals.push_back($urandom);
      end else if (kind < 85) begin
        len = $urandom_range(1, 8);
        repeat (len) run_vals.push_back(extremes[$urandom_range(0, extremes.size() - 1)]);
      end else begin
        len = $urandom_range(66, 80);
        repeat (len) begin
          if (run_vals.size() > 0 && $urandom_range(0, 7) == 0) begin
            run_vals.push_back(run_vals[$urandom_range(0, run_vals.size() - 1)]);
          end else begin
            run_vals.push_back($urandom);
          end
        end
      end
      send_run(run_vals);
      runs++;
      if (runs % 5 == 0) begin
        wait_for_drain();
      end
    end

    wait_for_drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/dvft_pkg.sv
src/dvft_front.sv
src/dvft_table.sv
src/distinct_value_frequency_table.sv
tb/distinct_value_frequency_table_tb.sv
